>>> design/blm_pkg.sv
// shared types, constants and microcode encodings for the battery level monitor
// no dependencies
package blm_pkg;

    // sizing
    localparam int AVG_DEPTH = 4;
    localparam int MV_W      = 14;
    localparam int CFG_W     = 13;
    localparam int CELLS_W   = 3;
    localparam int PCT_W     = 7;
    localparam int LVL_W     = 2;
    localparam int SLOT_W    = (AVG_DEPTH > 1) ? $clog2(AVG_DEPTH) : 1;
    localparam int FILL_W    = $clog2(AVG_DEPTH + 1);
    localparam int SUM_W     = MV_W + $clog2(AVG_DEPTH);
    localparam int PROD_W    = MV_W + PCT_W;
    localparam int DIV_RAW_W = (SUM_W > PROD_W) ? SUM_W : PROD_W;
    localparam int DIV_N_W   = DIV_RAW_W + (DIV_RAW_W % 2);
    localparam int DIV_D_W   = (CFG_W > FILL_W) ? CFG_W : FILL_W;
    localparam int DIV_ITER  = DIV_N_W / 2;
    localparam int DIV_CNT_W = $clog2(DIV_ITER + 1);
    localparam int CFG_IDX_W = 3;

    localparam logic [PCT_W-1:0]   PCT_FULL  = 7'd100;
    localparam logic [CELLS_W-1:0] MAX_CELLS = 3'd4;

    // level codes
    localparam logic [LVL_W-1:0] LVL_OK   = 2'd0;
    localparam logic [LVL_W-1:0] LVL_LOW  = 2'd1;
    localparam logic [LVL_W-1:0] LVL_CRIT = 2'd2;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_FULL   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_CUTOFF = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_LOW    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_CRIT   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_CELLS  = 3'd4;

    // microcode: datapath operations
    localparam int OP_W = 4;
    localparam logic [OP_W-1:0] OP_NOP      = 4'd0;
    localparam logic [OP_W-1:0] OP_STORE    = 4'd1;
    localparam logic [OP_W-1:0] OP_READ     = 4'd2;
    localparam logic [OP_W-1:0] OP_ACC      = 4'd3;
    localparam logic [OP_W-1:0] OP_DIV_AVG  = 4'd4;
    localparam logic [OP_W-1:0] OP_SAVE_AVG = 4'd5;
    localparam logic [OP_W-1:0] OP_SAVE_CEL = 4'd6;
    localparam logic [OP_W-1:0] OP_PREP     = 4'd7;
    localparam logic [OP_W-1:0] OP_DIV_PCT  = 4'd8;
    localparam logic [OP_W-1:0] OP_SAVE_PCT = 4'd9;
    localparam logic [OP_W-1:0] OP_FINISH   = 4'd10;

    // microcode: jump conditions
    localparam int COND_W = 3;
    localparam logic [COND_W-1:0] CND_NEVER    = 3'd0;
    localparam logic [COND_W-1:0] CND_ALWAYS   = 3'd1;
    localparam logic [COND_W-1:0] CND_NO_REQ   = 3'd2;
    localparam logic [COND_W-1:0] CND_MORE     = 3'd3;
    localparam logic [COND_W-1:0] CND_DIV_BUSY = 3'd4;
    localparam logic [COND_W-1:0] CND_CLAMP    = 3'd5;
    localparam logic [COND_W-1:0] CND_OUT_FULL = 3'd6;

    // microcode: program steps
    localparam int STEP_W = 4;
    localparam logic [STEP_W-1:0] ST_IDLE     = 4'd0;
    localparam logic [STEP_W-1:0] ST_READ     = 4'd1;
    localparam logic [STEP_W-1:0] ST_ACC      = 4'd2;
    localparam logic [STEP_W-1:0] ST_DIV_AVG  = 4'd3;
    localparam logic [STEP_W-1:0] ST_WAIT_AVG = 4'd4;
    localparam logic [STEP_W-1:0] ST_SAVE_AVG = 4'd5;
    localparam logic [STEP_W-1:0] ST_WAIT_CEL = 4'd6;
    localparam logic [STEP_W-1:0] ST_SAVE_CEL = 4'd7;
    localparam logic [STEP_W-1:0] ST_PREP     = 4'd8;
    localparam logic [STEP_W-1:0] ST_DIV_PCT  = 4'd9;
    localparam logic [STEP_W-1:0] ST_WAIT_PCT = 4'd10;
    localparam logic [STEP_W-1:0] ST_SAVE_PCT = 4'd11;
    localparam logic [STEP_W-1:0] ST_FINISH   = 4'd12;
    localparam logic [STEP_W-1:0] ST_RETURN   = 4'd13;

    typedef struct packed {
        logic [OP_W-1:0]   op;
        logic [COND_W-1:0] cond;
        logic [STEP_W-1:0] target;
    } ucode_t;

    typedef struct packed {
        logic more;
        logic div_busy;
        logic clamp;
    } dp_status_t;

    typedef struct packed {
        logic [CFG_W-1:0]   full_cell_mv;
        logic [CFG_W-1:0]   cutoff_cell_mv;
        logic [CFG_W-1:0]   low_cell_mv;
        logic [CFG_W-1:0]   critical_cell_mv;
        logic [CELLS_W-1:0] cells_in_series;
    } cfg_t;

    typedef struct packed {
        logic [MV_W-1:0]  avg_pack_mv;
        logic [MV_W-1:0]  avg_cell_mv;
        logic [PCT_W-1:0] charge_percent;
        logic [LVL_W-1:0] level_state;
        logic             state_changed;
    } result_t;

endpackage

>>> design/blm_ucode_rom.sv
// control store: one control word per program step
// depends on blm_pkg
module blm_ucode_rom (
    input  logic [blm_pkg::STEP_W-1:0] step,
    output blm_pkg::ucode_t            word
);
    import blm_pkg::*;

    always_comb
    begin
        case (step)
            ST_IDLE:     word = '{OP_STORE,    CND_NO_REQ,   ST_IDLE};
            ST_READ:     word = '{OP_READ,     CND_NEVER,    ST_IDLE};
            ST_ACC:      word = '{OP_ACC,      CND_MORE,     ST_READ};
            ST_DIV_AVG:  word = '{OP_DIV_AVG,  CND_NEVER,    ST_IDLE};
            ST_WAIT_AVG: word = '{OP_NOP,      CND_DIV_BUSY, ST_WAIT_AVG};
            ST_SAVE_AVG: word = '{OP_SAVE_AVG, CND_NEVER,    ST_IDLE};
            ST_WAIT_CEL: word = '{OP_NOP,      CND_DIV_BUSY, ST_WAIT_CEL};
            ST_SAVE_CEL: word = '{OP_SAVE_CEL, CND_NEVER,    ST_IDLE};
            ST_PREP:     word = '{OP_PREP,     CND_NEVER,    ST_IDLE};
            ST_DIV_PCT:  word = '{OP_DIV_PCT,  CND_CLAMP,    ST_FINISH};
            ST_WAIT_PCT: word = '{OP_NOP,      CND_DIV_BUSY, ST_WAIT_PCT};
            ST_SAVE_PCT: word = '{OP_SAVE_PCT, CND_NEVER,    ST_IDLE};
            ST_FINISH:   word = '{OP_FINISH,   CND_OUT_FULL, ST_FINISH};
            ST_RETURN:   word = '{OP_NOP,      CND_ALWAYS,   ST_IDLE};
            default:     word = '{OP_NOP,      CND_ALWAYS,   ST_IDLE};
        endcase
    end

endmodule

>>> design/blm_div.sv
// shared unsigned restoring divider, two quotient bits per cycle
// depends on blm_pkg
module blm_div (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        start,
    input  logic [blm_pkg::DIV_N_W-1:0] dividend,
    input  logic [blm_pkg::DIV_D_W-1:0] divisor,
    output logic                        busy,
    output logic [blm_pkg::DIV_N_W-1:0] quotient
);
    import blm_pkg::*;

    logic                 busy_reg, busy_next;
    logic [DIV_CNT_W-1:0] cnt_reg, cnt_next;
    logic [DIV_D_W-1:0]   rem_reg, rem_next;
    logic [DIV_N_W-1:0]   quo_reg, quo_next;
    logic [DIV_D_W-1:0]   dvs_reg;
    logic [DIV_D_W:0]     part1, part2;
    logic [DIV_D_W-1:0]   rem1;
    logic                 bit1, bit2;

    // two dependent shift-subtract steps
    always_comb
    begin
        part1 = {rem_reg, quo_reg[DIV_N_W-1]};
        bit1  = (part1 >= {1'b0, dvs_reg});
        rem1  = bit1 ? DIV_D_W'(part1 - {1'b0, dvs_reg}) : part1[DIV_D_W-1:0];
        part2 = {rem1, quo_reg[DIV_N_W-2]};
        bit2  = (part2 >= {1'b0, dvs_reg});
        rem_next = bit2 ? DIV_D_W'(part2 - {1'b0, dvs_reg}) : part2[DIV_D_W-1:0];
        quo_next = {quo_reg[DIV_N_W-3:0], bit1, bit2};
        busy_next = busy_reg;
        cnt_next  = cnt_reg;
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = '0;
        end
        else if (busy_reg)
        begin
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == DIV_CNT_W'(DIV_ITER - 1))
            begin
                busy_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg <= '0;
            quo_reg <= dividend;
            dvs_reg <= divisor;
        end
        else if (busy_reg)
        begin
            rem_reg <= rem_next;
            quo_reg <= quo_next;
        end
    end

    assign busy     = busy_reg;
    assign quotient = quo_reg;

endmodule

>>> design/blm_dp.sv
// datapath: sample ring, accumulator, divider operand select, percent and level logic
// depends on blm_pkg and blm_div
module blm_dp (
    input  logic                 clk,
    input  logic                 rst_n,
    input  blm_pkg::ucode_t      uc,
    input  logic                 accept,
    input  logic [blm_pkg::MV_W-1:0] pack_mv,
    input  blm_pkg::cfg_t        cfg,
    output blm_pkg::dp_status_t  status,
    output blm_pkg::result_t     result
);
    import blm_pkg::*;

    logic [MV_W-1:0]    ring_mem [AVG_DEPTH];
    logic [SLOT_W-1:0]  slot_reg, slot_next;
    logic [FILL_W-1:0]  fill_reg, fill_next;
    logic [LVL_W-1:0]   last_level_reg;
    logic [FILL_W-1:0]  idx_reg;
    logic [MV_W-1:0]    rd_reg;
    logic [SUM_W-1:0]   acc_reg;
    logic [MV_W-1:0]    avg_reg, cell_reg;
    logic [PROD_W-1:0]  prod_reg;
    logic [PCT_W-1:0]   pct_reg;
    logic [LVL_W-1:0]   level_reg, level_now;
    logic               changed_reg;
    logic               clamp_reg;
    logic               div_start, div_busy;
    logic [DIV_N_W-1:0] div_dividend, div_quotient;
    logic [DIV_D_W-1:0] div_divisor;
    logic [CELLS_W-1:0] cells_eff;
    logic [CFG_W-1:0]   span;
    logic [MV_W-1:0]    diff;
    logic               at_full, at_cutoff;

    // saturate the series count to one..four
    always_comb
    begin
        if (cfg.cells_in_series == '0)
        begin
            cells_eff = CELLS_W'(1);
        end
        else if (cfg.cells_in_series > MAX_CELLS)
        begin
            cells_eff = MAX_CELLS;
        end
        else
        begin
            cells_eff = cfg.cells_in_series;
        end
    end

    assign span      = cfg.full_cell_mv - cfg.cutoff_cell_mv;
    assign diff      = cell_reg - {1'b0, cfg.cutoff_cell_mv};
    assign at_full   = (cell_reg >= {1'b0, cfg.full_cell_mv});
    assign at_cutoff = (cell_reg <= {1'b0, cfg.cutoff_cell_mv});

    always_comb
    begin
        if (cell_reg <= {1'b0, cfg.critical_cell_mv})
        begin
            level_now = LVL_CRIT;
        end
        else if (cell_reg <= {1'b0, cfg.low_cell_mv})
        begin
            level_now = LVL_LOW;
        end
        else
        begin
            level_now = LVL_OK;
        end
    end

    // divider operand select
    always_comb
    begin
        div_start    = 1'b0;
        div_dividend = DIV_N_W'(acc_reg);
        div_divisor  = DIV_D_W'(fill_reg);
        case (uc.op)
            OP_DIV_AVG:
            begin
                div_start = 1'b1;
            end
            OP_SAVE_AVG:
            begin
                div_start    = 1'b1;
                div_dividend = DIV_N_W'(div_quotient[MV_W-1:0]);
                div_divisor  = DIV_D_W'(cells_eff);
            end
            OP_DIV_PCT:
            begin
                div_start    = !clamp_reg;
                div_dividend = DIV_N_W'(prod_reg);
                div_divisor  = DIV_D_W'(span);
            end
            default:
            begin
                div_start = 1'b0;
            end
        endcase
    end

    blm_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (div_dividend),
        .divisor  (div_divisor),
        .busy     (div_busy),
        .quotient (div_quotient)
    );

    // ring pointers and previous level
    always_comb
    begin
        slot_next = (slot_reg == SLOT_W'(AVG_DEPTH - 1)) ? '0 : SLOT_W'(slot_reg + 1'b1);
        fill_next = (fill_reg < FILL_W'(AVG_DEPTH)) ? FILL_W'(fill_reg + 1'b1) : fill_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            slot_reg       <= '0;
            fill_reg       <= '0;
            last_level_reg <= LVL_OK;
        end
        else
        begin
            if (uc.op == OP_STORE && accept)
            begin
                slot_reg <= slot_next;
                fill_reg <= fill_next;
            end
            if (uc.op == OP_PREP)
            begin
                last_level_reg <= level_now;
            end
        end
    end

    // ring storage, registered read
    always_ff @(posedge clk)
    begin
        if (uc.op == OP_STORE && accept)
        begin
            ring_mem[slot_reg] <= pack_mv;
        end
        if (uc.op == OP_READ)
        begin
            rd_reg <= ring_mem[idx_reg[SLOT_W-1:0]];
        end
    end

    always_ff @(posedge clk)
    begin
        case (uc.op)
            OP_STORE:
            begin
                acc_reg <= '0;
                idx_reg <= '0;
            end
            OP_READ:
            begin
                idx_reg <= FILL_W'(idx_reg + 1'b1);
            end
            OP_ACC:
            begin
                acc_reg <= SUM_W'(acc_reg + SUM_W'(rd_reg));
            end
            OP_SAVE_AVG:
            begin
                avg_reg <= div_quotient[MV_W-1:0];
            end
            OP_SAVE_CEL:
            begin
                cell_reg <= div_quotient[MV_W-1:0];
            end
            OP_PREP:
            begin
                level_reg   <= level_now;
                changed_reg <= (level_now != last_level_reg);
                clamp_reg   <= at_full || at_cutoff;
                pct_reg     <= at_full ? PCT_FULL : '0;
                prod_reg    <= PROD_W'(diff) * PROD_W'(PCT_FULL);
            end
            OP_SAVE_PCT:
            begin
                pct_reg <= div_quotient[PCT_W-1:0];
            end
            default:
            begin
                acc_reg <= acc_reg;
            end
        endcase
    end

    assign status.more     = (idx_reg < fill_reg);
    assign status.div_busy = div_busy;
    assign status.clamp    = clamp_reg;

    assign result.avg_pack_mv    = avg_reg;
    assign result.avg_cell_mv    = cell_reg;
    assign result.charge_percent = pct_reg;
    assign result.level_state    = level_reg;
    assign result.state_changed  = changed_reg;

endmodule

>>> design/battery_level_monitor_top.sv
// battery level monitor top: after acceptance the sequencer reads and sums every stored sample,
// then makes three divider passes for average, per-cell and percentage; a clamped percentage
// skips the last pass; the next request is taken only after the result enters the output register
// async active-low reset clears ring pointers, fill count, stored level and the sequencer
// depends on blm_pkg, blm_ucode_rom, blm_dp
module battery_level_monitor_top (
    input  logic                           clk,
    input  logic                           rst_n,
    // configuration write port
    input  logic                           cfg_we,
    input  logic [blm_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [blm_pkg::CFG_W-1:0]      cfg_data,
    // request channel
    input  logic                           in_valid,
    output logic                           in_ready,
    input  logic [blm_pkg::MV_W-1:0]       pack_mv,
    // result channel
    output logic                           out_valid,
    input  logic                           out_ready,
    output logic [blm_pkg::MV_W-1:0]       avg_pack_mv,
    output logic [blm_pkg::MV_W-1:0]       avg_cell_mv,
    output logic [blm_pkg::PCT_W-1:0]      charge_percent,
    output logic [blm_pkg::LVL_W-1:0]      level_state,
    output logic                           state_changed
);
    import blm_pkg::*;

    // configuration registers
    cfg_t cfg_reg;

    // sequencer
    logic [STEP_W-1:0] step_reg, step_next;
    ucode_t            uc;
    dp_status_t        st;
    result_t           res;
    logic              accept;
    logic              jump;

    // output register
    logic              out_valid_reg;
    result_t           out_reg;
    logic              out_full;
    logic              load_out;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.full_cell_mv     <= CFG_W'(4200);
            cfg_reg.cutoff_cell_mv   <= CFG_W'(3000);
            cfg_reg.low_cell_mv      <= CFG_W'(3400);
            cfg_reg.critical_cell_mv <= CFG_W'(3200);
            cfg_reg.cells_in_series  <= CELLS_W'(1);
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_FULL:   cfg_reg.full_cell_mv     <= cfg_data;
                CFG_CUTOFF: cfg_reg.cutoff_cell_mv   <= cfg_data;
                CFG_LOW:    cfg_reg.low_cell_mv      <= cfg_data;
                CFG_CRIT:   cfg_reg.critical_cell_mv <= cfg_data;
                CFG_CELLS:  cfg_reg.cells_in_series  <= cfg_data[CELLS_W-1:0];
                default:    cfg_reg <= cfg_reg;  // unknown index ignored
            endcase
        end
    end

    // control word for the current step
    blm_ucode_rom u_rom (
        .step (step_reg),
        .word (uc)
    );

    // the idle step is the only one that takes a request
    assign in_ready = (uc.op == OP_STORE);
    assign accept   = in_valid && in_ready;

    // output slot is busy while a result waits and is not taken this cycle
    assign out_full = out_valid_reg && !out_ready;
    assign load_out = (uc.op == OP_FINISH) && !out_full;

    // jump condition select
    always_comb
    begin
        case (uc.cond)
            CND_NEVER:    jump = 1'b0;
            CND_ALWAYS:   jump = 1'b1;
            CND_NO_REQ:   jump = !accept;
            CND_MORE:     jump = st.more;
            CND_DIV_BUSY: jump = st.div_busy;
            CND_CLAMP:    jump = st.clamp;
            CND_OUT_FULL: jump = out_full;
            default:      jump = 1'b1;
        endcase
        step_next = jump ? uc.target : STEP_W'(step_reg + 1'b1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg <= ST_IDLE;
        end
        else
        begin
            step_reg <= step_next;
        end
    end

    // datapath
    blm_dp u_dp (
        .clk     (clk),
        .rst_n   (rst_n),
        .uc      (uc),
        .accept  (accept),
        .pack_mv (pack_mv),
        .cfg     (cfg_reg),
        .status  (st),
        .result  (res)
    );

    // result register, decouples the sequencer from the consumer
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (load_out)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load_out)
        begin
            out_reg <= res;
        end
    end

    assign out_valid      = out_valid_reg;
    assign avg_pack_mv    = out_reg.avg_pack_mv;
    assign avg_cell_mv    = out_reg.avg_cell_mv;
    assign charge_percent = out_reg.charge_percent;
    assign level_state    = out_reg.level_state;
    assign state_changed  = out_reg.state_changed;

    // an accepted request moves the sequencer straight into the ring sum
    a_accept_starts : assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> (step_reg == ST_READ))
        else $error("sequencer did not leave idle after a request");

    // the shared divider is never restarted mid-division at the average and per-cell starts
    a_div_free : assert property (@(posedge clk) disable iff (!rst_n)
        (uc.op == OP_DIV_AVG || uc.op == OP_SAVE_AVG) |-> !st.div_busy)
        else $error("divider started while busy");

    // a taken result with nothing new behind it empties the output slot
    a_out_drain : assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_ready && !load_out) |=> !out_valid)
        else $error("result delivered twice");

    // percentage and level stay in range on every delivered result
    a_out_range : assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (charge_percent <= PCT_FULL && level_state <= LVL_CRIT))
        else $error("result field out of range");

endmodule
